// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the rtl, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define WTD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define WTD_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define WTD_ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define WTD_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== src/wtd_pkg.sv =====
// ----------------------------------------------------------------------------
// wtd_pkg
// types, codes and helpers of the windowed threshold detector
// ----------------------------------------------------------------------------
package wtd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int THRESHOLD_W   = 16;
    localparam int HOLDOFF_W     = 16;
    localparam int COUNT_W       = 32;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DETECT_ENABLE = 2'd0,
        CFG_THRESHOLD     = 2'd1,
        CFG_BLIND_TIME    = 2'd2
    } cfg_index_t;

    localparam logic [1:0] CODE_IDLE      = 2'd0;
    localparam logic [1:0] CODE_SEARCHING = 2'd1;
    localparam logic [1:0] CODE_REACHED   = 2'd2;
    localparam logic [1:0] CODE_MISSED    = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                window;
        logic                clear_inside;
        logic                clear_outside;
        logic                clear_missed;
        logic                ack_missed;
    } det_in_t;

    typedef struct packed {
        logic               rise;
        logic               fall;
        logic [1:0]         search_state;
        logic               missed_seen;
        logic [COUNT_W-1:0] inside_count;
        logic [COUNT_W-1:0] outside_count;
        logic [COUNT_W-1:0] missed_count;
    } det_out_t;

    // classified beat handed from front to back
    typedef struct packed {
        logic hit;
        logic window;
        logic clear_inside;
        logic clear_outside;
        logic clear_missed;
        logic ack_missed;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic                 detect_enable;
        logic [HOLDOFF_W-1:0] blind_time;
    } back_cfg_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ===== src/wtd_front.sv =====
// ----------------------------------------------------------------------------
// wtd_front
// input handshake and threshold classification of each sample beat
// ----------------------------------------------------------------------------
module wtd_front #(
    parameter int SAMPLE_BITS = wtd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wtd_pkg::det_in_t                    s_data,
    input  logic [wtd_pkg::THRESHOLD_W-1:0]     threshold,
    input  wtd_pkg::q_status_t                  q_status,
    output logic                                push,
    output wtd_pkg::q_entry_t                   push_entry
);
    import wtd_pkg::*;

    logic [SAMPLE_W-1:0] sample_masked;

    // sample bits at index SAMPLE_BITS and above are ignored
    always_comb begin
        for (int i = 0; i < SAMPLE_W; i++) begin
            sample_masked[i] = s_data.sample[i] & (i < SAMPLE_BITS);
        end
    end

    assign s_ready = ~q_status.full;
    assign push    = s_valid & s_ready;

    always_comb begin
        push_entry.hit           = (sample_masked >= threshold);
        push_entry.window        = s_data.window;
        push_entry.clear_inside  = s_data.clear_inside;
        push_entry.clear_outside = s_data.clear_outside;
        push_entry.clear_missed  = s_data.clear_missed;
        push_entry.ack_missed    = s_data.ack_missed;
    end

endmodule

// ===== src/wtd_queue.sv =====
// ----------------------------------------------------------------------------
// wtd_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module wtd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wtd_pkg::q_entry_t   push_entry,
    input  logic                pop,
    output wtd_pkg::q_entry_t   pop_entry,
    output wtd_pkg::q_status_t  status
);
    import wtd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== src/wtd_back.sv =====
// ----------------------------------------------------------------------------
// wtd_back
// edge detection, hold-off, search state, counters and output register
// ----------------------------------------------------------------------------
module wtd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  wtd_pkg::back_cfg_t  cfg,
    input  wtd_pkg::q_status_t  q_status,
    input  wtd_pkg::q_entry_t   q_entry,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output wtd_pkg::det_out_t   m_data
);
    import wtd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SEARCH  = 4'b0010,
        S_REACHED = 4'b0100,
        S_MISSED  = 4'b1000
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 prev_win_reg, prev_win_next;
    logic [HOLDOFF_W-1:0] hold_reg, hold_next;
    logic [COUNT_W-1:0]   inside_reg, inside_next;
    logic [COUNT_W-1:0]   outside_reg, outside_next;
    logic [COUNT_W-1:0]   missed_reg, missed_next;
    logic                 rise, fall, seen;
    logic                 out_valid_reg, out_valid_next;
    det_out_t             out_reg;
    logic [1:0]           mode_code;

    assign pop = ~q_status.empty & (~out_valid_reg | m_ready);

    always_comb begin
        inside_next   = q_entry.clear_inside  ? '0 : inside_reg;
        outside_next  = q_entry.clear_outside ? '0 : outside_reg;
        missed_next   = q_entry.clear_missed  ? '0 : missed_reg;
        mode_next     = mode_reg;
        prev_win_next = prev_win_reg;
        hold_next     = hold_reg;
        rise          = 1'b0;
        fall          = 1'b0;
        seen          = 1'b0;
        if (q_entry.ack_missed && mode_reg == S_MISSED) begin
            mode_next = S_IDLE;
            seen      = 1'b1;
        end
        if (cfg.detect_enable) begin
            rise          = q_entry.window & ~prev_win_reg;
            fall          = ~q_entry.window & prev_win_reg;
            prev_win_next = q_entry.window;
            if (hold_reg != '0) begin
                hold_next = hold_reg - HOLDOFF_W'(1);
            end
            if (q_entry.hit && hold_next == '0) begin
                mode_next = S_REACHED;
                hold_next = cfg.blind_time;
            end
            if (rise) begin
                mode_next = S_SEARCH;
            end else if (fall) begin
                if (mode_next == S_SEARCH) begin
                    mode_next   = S_MISSED;
                    missed_next = sat_inc(missed_next);
                end
            end else if (mode_next == S_REACHED) begin
                if (q_entry.window) begin
                    inside_next = sat_inc(inside_next);
                end else begin
                    outside_next = sat_inc(outside_next);
                end
                mode_next = S_IDLE;
            end
        end
    end

    always_comb begin
        case (mode_next)
            S_IDLE:    mode_code = CODE_IDLE;
            S_SEARCH:  mode_code = CODE_SEARCHING;
            S_REACHED: mode_code = CODE_REACHED;
            S_MISSED:  mode_code = CODE_MISSED;
            default:   mode_code = CODE_IDLE;
        endcase
    end

    always_comb begin
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= S_IDLE;
            prev_win_reg  <= 1'b0;
            hold_reg      <= '0;
            inside_reg    <= '0;
            outside_reg   <= '0;
            missed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                mode_reg     <= mode_next;
                prev_win_reg <= prev_win_next;
                hold_reg     <= hold_next;
                inside_reg   <= inside_next;
                outside_reg  <= outside_next;
                missed_reg   <= missed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg.rise          <= rise;
            out_reg.fall          <= fall;
            out_reg.search_state  <= mode_code;
            out_reg.missed_seen   <= seen;
            out_reg.inside_count  <= inside_next;
            out_reg.outside_count <= outside_next;
            out_reg.missed_count  <= missed_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/windowed_threshold_detector_core.sv =====
// path: accepted beat -> queue slot -> back end output register -> m_data
// throughput: one sample beat per cycle while results are taken, set by the back end pop
// a two-entry queue between front and back holds up to two beats while a result stalls
// reset: aresetn synchronous active low; clears config, search state, hold-off and counters
// ----------------------------------------------------------------------------
// windowed_threshold_detector_core
// threshold detector with trigger window edge tracking, hold-off and
// saturating inside, outside and missed counters
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_threshold_detector_core #(
    parameter int SAMPLE_BITS = wtd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [wtd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wtd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wtd_pkg::det_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output wtd_pkg::det_out_t                   m_data
);
    import wtd_pkg::*;

    logic                   detect_enable_reg;
    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [HOLDOFF_W-1:0]   blind_time_reg;
    back_cfg_t              back_cfg;
    q_status_t              q_status;
    q_entry_t               push_entry, pop_entry;
    logic                   push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_enable_reg <= 1'b0;
            threshold_reg     <= '0;
            blind_time_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_DETECT_ENABLE: detect_enable_reg <= cfg_wdata[0];
                CFG_THRESHOLD:     threshold_reg     <= THRESHOLD_W'(cfg_wdata);
                CFG_BLIND_TIME:    blind_time_reg    <= HOLDOFF_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign back_cfg.detect_enable = detect_enable_reg;
    assign back_cfg.blind_time    = blind_time_reg;

    wtd_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .threshold  (threshold_reg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    wtd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    wtd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (back_cfg),
        .q_status (q_status),
        .q_entry  (pop_entry),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `WTD_ASSERT_IMPLY(a_pop_needs_entry, aclk, aresetn, pop, !q_status.empty)
    `WTD_ASSERT_IMPLY(a_full_blocks_input, aclk, aresetn, q_status.full, !s_ready)
    `WTD_ASSERT_NEVER(a_no_double_edge, aclk, aresetn, m_valid && m_data.rise && m_data.fall)
    `WTD_ASSERT_IMPLY(a_disabled_no_edge, aclk, aresetn, m_valid && !detect_enable_reg, !m_data.rise && !m_data.fall)

endmodule

// ===== tb/sv/windowed_threshold_detector_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_threshold_detector_core_test
// self-checking bench for the windowed threshold detector: sample beats are
// queued by a sequencer, sent by a clocked driver with random gaps and checked
// by a clocked monitor against a cycle-free prediction of the detector state
// (edge tracking, hold-off, search state and saturating counters), over several
// register settings including the extremes and a long result back-pressure
// ----------------------------------------------------------------------------
module windowed_threshold_detector_core_test;

    import wtd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_WAIT  = 8;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    det_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    det_out_t    m_data;

    windowed_threshold_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // register copies
    logic        enable_reg    = 1'b0;
    logic [15:0] threshold_reg = '0;
    logic [15:0] blind_reg     = '0;

    // detector state copies
    logic         last_window   = 1'b0;
    logic [15:0]  holdoff_count = '0;
    logic [1:0]   search_mode   = CODE_IDLE;
    logic [31:0]  inside_hits   = '0;
    logic [31:0]  outside_hits  = '0;
    logic [31:0]  missed_windows = '0;

    det_in_t      pending_beats[$];
    det_out_t     expected_status[$];

    int unsigned  fault_count    = 0;
    int unsigned  accepted_beats = 0;
    int unsigned  send_gap       = 0;
    int unsigned  recv_gap       = 0;
    int unsigned  hold_left      = 0;
    logic         hold_done      = 1'b0;
    int unsigned  cycle_count    = 0;
    logic         calm           = 1'b0;

    logic         window_level   = 1'b0;
    int unsigned  window_run     = 0;

    function automatic logic [31:0] count_up(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned pick_gap(input logic quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic det_out_t predict_status(input det_in_t beat);
        det_out_t st;
        logic     went_up;
        logic     went_down;
        st        = '0;
        went_up   = 1'b0;
        went_down = 1'b0;
        if (beat.clear_inside)
            inside_hits = '0;
        if (beat.clear_outside)
            outside_hits = '0;
        if (beat.clear_missed)
            missed_windows = '0;
        if (beat.ack_missed && search_mode == CODE_MISSED) begin
            search_mode    = CODE_IDLE;
            st.missed_seen = 1'b1;
        end
        if (enable_reg) begin
            went_up     = beat.window && !last_window;
            went_down   = !beat.window && last_window;
            last_window = beat.window;
            if (holdoff_count != 0)
                holdoff_count = holdoff_count - 16'd1;
            if (beat.sample >= threshold_reg && holdoff_count == 0) begin
                search_mode   = CODE_REACHED;
                holdoff_count = blind_reg;
            end
            if (went_up) begin
                search_mode = CODE_SEARCHING;
            end else if (went_down) begin
                if (search_mode == CODE_SEARCHING) begin
                    search_mode    = CODE_MISSED;
                    missed_windows = count_up(missed_windows);
                end
            end else if (search_mode == CODE_REACHED) begin
                if (beat.window)
                    inside_hits = count_up(inside_hits);
                else
                    outside_hits = count_up(outside_hits);
                search_mode = CODE_IDLE;
            end
        end
        st.rise          = went_up;
        st.fall          = went_down;
        st.search_state  = search_mode;
        st.inside_count  = inside_hits;
        st.outside_count = outside_hits;
        st.missed_count  = missed_windows;
        return st;
    endfunction

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge aclk) begin : drive_beats
        logic next_valid;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_status.insert(expected_status.size(), predict_status(s_data));
                accepted_beats <= accepted_beats + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_beats.size() != 0) begin
                    s_data     <= pending_beats.pop_front();
                    next_valid = 1'b1;
                    send_gap   <= pick_gap(calm);
                end
            end
            s_valid <= next_valid;
        end
    end

    // monitor
    always @(posedge aclk) begin : check_results
        det_out_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t result beat with nothing expected: %h", $time, m_data);
                end else begin
                    want = expected_status.pop_front();
                    flag_field("rise", want.rise, m_data.rise);
                    flag_field("fall", want.fall, m_data.fall);
                    flag_field("search_state", want.search_state, m_data.search_state);
                    flag_field("missed_seen", want.missed_seen, m_data.missed_seen);
                    flag_field("inside_count", want.inside_count, m_data.inside_count);
                    flag_field("outside_count", want.outside_count, m_data.outside_count);
                    flag_field("missed_count", want.missed_count, m_data.missed_count);
                end
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready)
                    recv_gap <= pick_gap(calm);
            end
        end
    end

    // long back-pressure once the run is well under way
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_beats >= 320) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic det_in_t make_beat(input logic [15:0] sample, input logic window,
                                          input logic ci, input logic co,
                                          input logic cm, input logic ack);
        det_in_t b;
        b.sample        = sample;
        b.window        = window;
        b.clear_inside  = ci;
        b.clear_outside = co;
        b.clear_missed  = cm;
        b.ack_missed    = ack;
        return b;
    endfunction

    // appends one beat to the pending list
    task automatic queue_beat(input det_in_t b);
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_status.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_DETECT_ENABLE: enable_reg    = value[0];
            CFG_THRESHOLD:     threshold_reg = value;
            CFG_BLIND_TIME:    blind_reg     = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic en, input logic [15:0] thr,
                                  input logic [15:0] blind);
        wait_drained();
        write_reg(CFG_DETECT_ENABLE, {15'd0, en});
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_BLIND_TIME, blind);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // windows as runs of random length, with some noise on the window bit
    task automatic queue_random_beats(input int unsigned count);
        det_in_t     b;
        int unsigned r;
        int          near_level;
        for (int unsigned i = 0; i < count; i++) begin
            if (window_run == 0) begin
                window_level = ~window_level;
                window_run   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                           : $urandom_range(1, 12);
            end
            window_run--;
            b.window = ($urandom_range(0, 99) < 8) ? 1'($urandom_range(0, 1)) : window_level;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                b.sample = 16'($urandom_range(0, 65535));
            end else if (r < 50) begin
                near_level = int'(threshold_reg) + int'($urandom_range(0, 6)) - 3;
                if (near_level < 0)
                    near_level = 0;
                if (near_level > 65535)
                    near_level = 65535;
                b.sample = 16'(near_level);
            end else if (r < 65) begin
                b.sample = '0;
            end else if (r < 75) begin
                b.sample = 16'hFFFF;
            end else begin
                b.sample = 16'($urandom_range(0, threshold_reg));
            end
            b.clear_inside  = ($urandom_range(0, 99) < 3);
            b.clear_outside = ($urandom_range(0, 99) < 3);
            b.clear_missed  = ($urandom_range(0, 99) < 3);
            b.ack_missed    = ($urandom_range(0, 99) < 20);
            queue_beat(b);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // detection off after reset: only clears and acknowledge act
        queue_beat(make_beat(16'd5000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        queue_beat(make_beat(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));

        apply_settings(1'b1, 16'd1000, 16'd0);
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // window opens and closes without a hit: miss, then acknowledge twice
        queue_beat(make_beat(16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // just below and exactly at the threshold inside the window
        queue_beat(make_beat(16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd999,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        // hit on a falling edge stays pending until the next plain beat
        queue_beat(make_beat(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // hit on a rising edge gives way to the search
        queue_beat(make_beat(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // hit while a miss is pending
        queue_beat(make_beat(16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'd2000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // clears together with an acknowledge
        queue_beat(make_beat(16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'h5555, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_beat(make_beat(16'hAAAA, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        queue_beat(make_beat(16'd0,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0));

        apply_settings(1'b1, 16'($urandom_range(16'h4000, 16'hC000)), 16'd0);
        queue_random_beats(113);

        calm = 1'b1;
        apply_settings(1'b1, 16'd0, 16'd3);
        queue_random_beats(113);

        calm = 1'b0;
        apply_settings(1'b1, 16'hFFFF, 16'd1);
        queue_random_beats(113);

        apply_settings(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        queue_random_beats(113);

        apply_settings(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 20)));
        queue_random_beats(113);

        // longest hold-off last, since after its first hit it blocks further hits for the rest of the run
        apply_settings(1'b1, 16'($urandom_range(0, 65535)), 16'hFFFF);
        queue_random_beats(113);

        wait_drained();
        if (fault_count == 0 && expected_status.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== windowed_threshold_detector_core.f =====
+incdir+src
src/wtd_pkg.sv
src/wtd_front.sv
src/wtd_queue.sv
src/wtd_back.sv
src/windowed_threshold_detector_core.sv
tb/sv/windowed_threshold_detector_core_test.sv
